/* rtl/core/lpbc_pkg.sv */
// Package of the lidar point box classifier: codes, item and register types,
// and the saturating arithmetic that the core uses.
// It depends on nothing else.
package lpbc_pkg;

   localparam int MAX_BOXES       = 64;
   localparam int BOX_IDX_W       = $clog2(MAX_BOXES);
   localparam int BOX_CNT_W       = $clog2(MAX_BOXES + 1);
   localparam int COORD_FRAC_BITS = 16;
   localparam int NUM_COEFS       = 36;
   localparam int COEF_IDX_W      = 6;
   localparam int DIV_DVD_W       = 68;
   localparam int DIV_CNT_W       = 7;
   localparam int MAC_TERMS       = 12;
   localparam int REQ_DATA_W      = 184;
   localparam int RSP_DATA_W      = 136;

   localparam logic signed [63:0] SAT_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [31:0] COORD_ONE = 32'(64'd1 << COORD_FRAC_BITS);

   localparam logic [2:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_MATCH_MARGIN = 3'd2;
   localparam logic [2:0] CSR_CENTER_SHIFT = 3'd3;
   localparam logic [2:0] CSR_RIGHT_SHIFT  = 3'd4;
   localparam logic [2:0] CSR_LEFT_SHIFT   = 3'd5;

   typedef enum logic [1:0] {
      CMD_COEF  = 2'd0,
      CMD_BOX   = 2'd1,
      CMD_POINT = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CAM_CENTER = 2'd0,
      CAM_RIGHT  = 2'd1,
      CAM_LEFT   = 2'd2,
      CAM_NONE   = 2'd3
   } cam_type;

   typedef enum logic [2:0] {
      VERDICT_BLUE   = 3'd0,
      VERDICT_YELLOW = 3'd1,
      VERDICT_BOTH   = 3'd2,
      VERDICT_NONE   = 3'd3,
      VERDICT_OOV    = 3'd4,
      VERDICT_NO_SET = 3'd5
   } verdict_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DEPTH,
      ST_DIV,
      ST_CHECK,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [11:0] image_width;
      logic [11:0] image_height;
      logic [7:0]  match_margin;
      logic [11:0] center_shift;
      logic [11:0] right_shift;
      logic [11:0] left_shift;
   } cfg_type;

   typedef struct packed {
      cmd_type                 command;
      logic [COEF_IDX_W-1:0]   coef_index;
      logic signed [31:0]      coef_value;
      logic [11:0]             box_xmin;
      logic [11:0]             box_xmax;
      logic [11:0]             box_ymin;
      logic [11:0]             box_ymax;
      logic [1:0]              box_class;
      logic                    group_last;
      logic signed [31:0]      point_x;
      logic signed [31:0]      point_y;
      logic signed [31:0]      point_z;
   } req_type;

   typedef struct packed {
      cam_type             camera_used;
      verdict_type         verdict;
      logic signed [15:0]  pixel_col;
      logic signed [15:0]  pixel_row;
      logic signed [31:0]  echo_x;
      logic signed [31:0]  echo_y;
      logic signed [31:0]  echo_z;
   } res_type;

   typedef struct packed {
      logic [11:0] xmin;
      logic [11:0] xmax;
      logic [11:0] ymin;
      logic [11:0] ymax;
      logic [1:0]  cls;
   } box_type;

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s > $signed({1'b0, SAT_MAX})) begin
         return SAT_MAX;
      end else if (s < -$signed({1'b0, SAT_MAX})) begin
         return -SAT_MAX;
      end
      return s[63:0];
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
      if (v > 32'sd32767) begin
         return 16'sh7FFF;
      end else if (v < -32'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

endpackage

/* rtl/core/lpbc_divider.sv */
// Restoring divider, one quotient bit per cycle, giving a signed quotient
// with four fraction bits and its magnitude clamped to 2^30.
// It depends on lpbc_pkg.
module lpbc_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] num,
   input  logic signed [63:0] den,
   output logic               done,
   output logic signed [31:0] quot
);
   import lpbc_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  neg_ff, neg_in;
   logic [DIV_DVD_W-1:0]  dvd_ff, dvd_in;
   logic [64:0]           rem_ff, rem_in;
   logic [63:0]           den_ff, den_in;
   logic signed [31:0]    quot_ff, quot_in;

   logic [64:0]           rem_sh;
   logic                  ge;
   logic [DIV_DVD_W-1:0]  dvd_nx;
   logic [63:0]           num_mag, den_mag;
   logic [31:0]           mag;

   always_comb begin
      num_mag = num[63] ? 64'(-num) : 64'(num);
      den_mag = den[63] ? 64'(-den) : 64'(den);
      rem_sh  = {rem_ff[63:0], dvd_ff[DIV_DVD_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      dvd_nx  = {dvd_ff[DIV_DVD_W-2:0], ge};
      mag     = (|dvd_nx[DIV_DVD_W-1:30]) ? 32'h4000_0000 : {2'b00, dvd_nx[29:0]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = num[63] ^ den[63];
         dvd_in  = {num_mag, 4'b0000};
         rem_in  = '0;
         den_in  = den_mag;
      end else if (busy_ff) begin
         rem_in = ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;
         dvd_in = dvd_nx;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            quot_in = neg_ff ? -$signed(mag) : $signed(mag);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

/* rtl/core/lpbc_core.sv */
// Classifier core: coefficient and box memories, the multiply-accumulate
// sequencer, camera selection and the box scan.
// It depends on lpbc_pkg and lpbc_divider.
module lpbc_core (
   input  logic              clock,
   input  logic              reset,
   input  lpbc_pkg::cfg_type cfg,
   input  logic              req_valid,
   input  lpbc_pkg::req_type req,
   output logic              in_ready,
   output logic              res_valid,
   input  logic              res_ready,
   output lpbc_pkg::res_type res
);
   import lpbc_pkg::*;

   box_type               box_mem  [MAX_BOXES];

   state_type             state_ff, state_in;
   cam_type               cam_ff;
   logic [3:0]            mc_ff, t1_ff, t2_ff;
   logic                  v1_ff, v2_ff;
   logic signed [31:0]    coef_rd_ff;
   logic signed [63:0]    prod_ff;
   logic signed [63:0]    acc_ff [3];
   logic signed [31:0]    px_ff, py_ff, pz_ff;
   logic                  last_ff;
   logic                  held_ff;
   logic [BOX_CNT_W-1:0]  count_ff;
   logic [BOX_CNT_W-1:0]  sc_ff;
   logic                  sv_ff;
   box_type               box_rd_ff;
   logic                  blue_ff, yellow_ff;
   logic signed [31:0]    col_ff, row_ff;
   verdict_type           verdict_ff;

   logic signed [31:0]    coef_words [NUM_COEFS];
   logic [COEF_IDX_W-1:0] coef_addr;
   logic signed [31:0]    operand;
   logic                  depth_zero;
   logic                  div_start, div_done, div_done_row;
   logic signed [31:0]    div_col, div_row;
   logic                  in_view, scan_end, hit, accept;
   logic signed [31:0]    lim_w, lim_h, shift, xlo, xhi, ylo, yhi;

   always_comb begin
      coef_addr = COEF_IDX_W'({cam_ff, 3'b000}) + COEF_IDX_W'({cam_ff, 2'b00})
                + COEF_IDX_W'({mc_ff[3:2], 2'b00})
                + ((mc_ff[1:0] == 2'd0) ? COEF_IDX_W'(3) : COEF_IDX_W'(mc_ff[1:0] - 2'd1));
      case (t1_ff[1:0])
         2'd0:    operand = COORD_ONE;
         2'd1:    operand = px_ff;
         2'd2:    operand = py_ff;
         default: operand = pz_ff;
      endcase
      depth_zero = acc_ff[2] == 64'sd0;
      lim_w   = $signed({16'd0, cfg.image_width, 4'd0});
      lim_h   = $signed({16'd0, cfg.image_height, 4'd0});
      in_view = div_col >= 0 && div_col <= lim_w && div_row >= 0 && div_row <= lim_h;
      case (cam_ff)
         CAM_CENTER: shift = $signed({20'd0, cfg.center_shift});
         CAM_RIGHT:  shift = $signed({20'd0, cfg.right_shift});
         default:    shift = $signed({20'd0, cfg.left_shift});
      endcase
      xlo = ($signed({20'd0, box_rd_ff.xmin}) - shift - $signed({24'd0, cfg.match_margin})) <<< 4;
      xhi = ($signed({20'd0, box_rd_ff.xmax}) - shift + $signed({24'd0, cfg.match_margin})) <<< 4;
      ylo = ($signed({20'd0, box_rd_ff.ymin}) - $signed({24'd0, cfg.match_margin})) <<< 4;
      yhi = ($signed({20'd0, box_rd_ff.ymax}) + $signed({24'd0, cfg.match_margin})) <<< 4;
      hit = col_ff >= xlo && col_ff <= xhi && row_ff >= ylo && row_ff <= yhi;
      scan_end = (sc_ff == count_ff) && !sv_ff;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid && req.command == CMD_POINT) state_in = ST_MAC;
         ST_MAC:   if (mc_ff == 4'(MAC_TERMS + 1)) state_in = ST_DEPTH;
         ST_DEPTH: begin
            if (!depth_zero) state_in = ST_DIV;
            else state_in = (cam_ff == CAM_LEFT) ? ST_DONE : ST_MAC;
         end
         ST_DIV:   if (div_done && div_done_row) state_in = ST_CHECK;
         ST_CHECK: begin
            if (in_view) state_in = held_ff ? ST_SCAN : ST_DONE;
            else state_in = (cam_ff == CAM_LEFT) ? ST_DONE : ST_MAC;
         end
         ST_SCAN:  if (scan_end) state_in = ST_DONE;
         ST_DONE:  if (res_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      in_ready  = 1'b0;
      res_valid = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         ST_IDLE:  in_ready  = 1'b1;
         ST_DEPTH: div_start = !depth_zero;
         ST_DONE:  res_valid = 1'b1;
         default:  in_ready  = 1'b0;
      endcase
   end

   assign accept = in_ready && req_valid;

   lpbc_divider u_div_col (
      .clock (clock), .reset (reset), .start (div_start),
      .num (acc_ff[0]), .den (acc_ff[2]), .done (div_done), .quot (div_col)
   );

   lpbc_divider u_div_row (
      .clock (clock), .reset (reset), .start (div_start),
      .num (acc_ff[1]), .den (acc_ff[2]), .done (div_done_row), .quot (div_row)
   );

   always_ff @(posedge clock) begin
      if (accept && req.command == CMD_COEF && req.coef_index < COEF_IDX_W'(NUM_COEFS)) begin
         coef_words[req.coef_index] <= req.coef_value;
      end
      coef_rd_ff <= coef_words[coef_addr];
   end

   always_ff @(posedge clock) begin
      if (accept && req.command == CMD_BOX && !held_ff && count_ff < BOX_CNT_W'(MAX_BOXES)) begin
         box_mem[count_ff[BOX_IDX_W-1:0]] <= {req.box_xmin, req.box_xmax, req.box_ymin,
                                              req.box_ymax, req.box_class};
      end
      box_rd_ff <= box_mem[sc_ff[BOX_IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         held_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (accept && req.command == CMD_BOX && !held_ff) begin
            if (count_ff < BOX_CNT_W'(MAX_BOXES)) count_ff <= count_ff + 1'b1;
            if (req.group_last) held_ff <= 1'b1;
         end
         if (state_ff == ST_DONE && res_ready && last_ff) begin
            held_ff  <= 1'b0;
            count_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            px_ff   <= req.point_x;
            py_ff   <= req.point_y;
            pz_ff   <= req.point_z;
            last_ff <= req.group_last;
            cam_ff  <= CAM_CENTER;
            mc_ff   <= '0;
            v1_ff   <= 1'b0;
            v2_ff   <= 1'b0;
         end
         ST_MAC: begin
            mc_ff   <= mc_ff + 1'b1;
            v1_ff   <= mc_ff < 4'(MAC_TERMS);
            t1_ff   <= mc_ff;
            v2_ff   <= v1_ff;
            t2_ff   <= t1_ff;
            prod_ff <= coef_rd_ff * operand;
            if (v2_ff) begin
               if (t2_ff[1:0] == 2'd0) acc_ff[t2_ff[3:2]] <= prod_ff;
               else acc_ff[t2_ff[3:2]] <= sat_add(acc_ff[t2_ff[3:2]], prod_ff);
            end
         end
         ST_DEPTH, ST_CHECK: begin
            mc_ff     <= '0;
            v1_ff     <= 1'b0;
            v2_ff     <= 1'b0;
            sc_ff     <= '0;
            sv_ff     <= 1'b0;
            blue_ff   <= 1'b0;
            yellow_ff <= 1'b0;
            if (state_ff == ST_CHECK && in_view) begin
               col_ff     <= div_col;
               row_ff     <= div_row;
               verdict_ff <= VERDICT_NO_SET;
            end else if (state_ff == ST_CHECK || depth_zero) begin
               if (cam_ff == CAM_LEFT) begin
                  cam_ff     <= CAM_NONE;
                  col_ff     <= '0;
                  row_ff     <= '0;
                  verdict_ff <= held_ff ? VERDICT_OOV : VERDICT_NO_SET;
               end else begin
                  cam_ff <= cam_type'(cam_ff + 2'd1);
               end
            end
         end
         ST_SCAN: begin
            sv_ff <= sc_ff < count_ff;
            if (sc_ff < count_ff) sc_ff <= sc_ff + 1'b1;
            if (sv_ff && hit) begin
               if (cam_ff == CAM_RIGHT) begin
                  if (box_rd_ff.cls == 2'd1) yellow_ff <= 1'b1;
                  else blue_ff <= 1'b1;
               end else begin
                  if (box_rd_ff.cls == 2'd0) blue_ff <= 1'b1;
                  else yellow_ff <= 1'b1;
               end
            end
            if (scan_end) begin
               verdict_ff <= blue_ff ? (yellow_ff ? VERDICT_BOTH : VERDICT_BLUE)
                                     : (yellow_ff ? VERDICT_YELLOW : VERDICT_NONE);
            end
         end
         default: mc_ff <= mc_ff;
      endcase
   end

   always_comb begin
      res.camera_used = cam_ff;
      res.verdict     = verdict_ff;
      res.pixel_col   = sat16(col_ff);
      res.pixel_row   = sat16(row_ff);
      res.echo_x      = px_ff;
      res.echo_y      = py_ff;
      res.echo_z      = pz_ff;
   end

endmodule

/* rtl/core/lidar_point_box_classifier.sv */
// Top level of the lidar point box classifier: register port, item packing
// and the result register.
// It depends on lpbc_pkg and lpbc_core.
//
//   channel  direction  handshake           payload
//   req_     in         tvalid/tready       tdata, tuser (command), tlast
//   rsp_     out        tvalid/tready       tdata
//   csr_     in         wen, no wait        index, wdata
//
// Coefficient and box items are accepted back to back while no point is in progress.
// A point passes the accept state, then for each camera the multiply-accumulate
// sequence and the depth test, and for a non-zero depth the divider pair and the
// image test; when a camera sees the point and a box set is held, a box scan over
// the stored boxes follows, and then the result waits in the done state.
// Reset is synchronous and clears the registers to their defaults and the box set.
// A result waits in the output register while the core takes the next item.
module lidar_point_box_classifier (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // coef_index, coef_value, box_xmin, box_xmax, box_ymin, box_ymax, box_class,
   // point_x, point_y, point_z
   input  logic [lpbc_pkg::REQ_DATA_W-1:0]  req_tdata,
   // command
   input  logic [1:0]                       req_tuser,
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // camera_used, verdict, pixel_col, pixel_row, echo_x, echo_y, echo_z, zero fill
   output logic [lpbc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_wen,
   input  logic [2:0]                       csr_index,
   input  logic [11:0]                      csr_wdata
);
   import lpbc_pkg::*;

   cfg_type  cfg_ff;
   req_type  req;
   res_type  core_res;
   logic     core_res_valid, core_in_ready, res_ready;
   logic     rsp_valid_ff;
   res_type  rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= 12'd640;
         cfg_ff.image_height <= 12'd480;
         cfg_ff.match_margin <= 8'd0;
         cfg_ff.center_shift <= 12'd640;
         cfg_ff.right_shift  <= 12'd1280;
         cfg_ff.left_shift   <= 12'd0;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  cfg_ff.image_width  <= csr_wdata;
            CSR_IMAGE_HEIGHT: cfg_ff.image_height <= csr_wdata;
            CSR_MATCH_MARGIN: cfg_ff.match_margin <= csr_wdata[7:0];
            CSR_CENTER_SHIFT: cfg_ff.center_shift <= csr_wdata;
            CSR_RIGHT_SHIFT:  cfg_ff.right_shift  <= csr_wdata;
            CSR_LEFT_SHIFT:   cfg_ff.left_shift   <= csr_wdata;
            default:          cfg_ff.left_shift   <= cfg_ff.left_shift;
         endcase
      end
   end

   always_comb begin
      req.command    = cmd_type'(req_tuser);
      req.coef_index = req_tdata[5:0];
      req.coef_value = req_tdata[37:6];
      req.box_xmin   = req_tdata[49:38];
      req.box_xmax   = req_tdata[61:50];
      req.box_ymin   = req_tdata[73:62];
      req.box_ymax   = req_tdata[85:74];
      req.box_class  = req_tdata[87:86];
      req.group_last = req_tlast;
      req.point_x    = req_tdata[119:88];
      req.point_y    = req_tdata[151:120];
      req.point_z    = req_tdata[183:152];
   end

   assign res_ready = !rsp_valid_ff || rsp_tready;

   lpbc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_tvalid),
      .req       (req),
      .in_ready  (core_in_ready),
      .res_valid (core_res_valid),
      .res_ready (res_ready),
      .res       (core_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= core_res_valid;
      end
      if (res_ready && core_res_valid) begin
         rsp_data_ff <= core_res;
      end
   end

   assign req_tready = core_in_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff.echo_z, rsp_data_ff.echo_y, rsp_data_ff.echo_x,
                        rsp_data_ff.pixel_row, rsp_data_ff.pixel_col,
                        rsp_data_ff.verdict, rsp_data_ff.camera_used};

   a_point_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == CMD_POINT) |=> !req_tready)
      else $error("point item did not close the input");

   a_no_camera_zero: assert property (@(posedge clock) disable iff (reset)
      (core_res_valid && core_res.camera_used == CAM_NONE) |->
      (core_res.pixel_col == 16'sd0 && core_res.pixel_row == 16'sd0))
      else $error("pixel not zero without a camera");

   a_oov_camera: assert property (@(posedge clock) disable iff (reset)
      (core_res_valid && core_res.verdict == VERDICT_OOV) |-> core_res.camera_used == CAM_NONE)
      else $error("out of view with a camera chosen");

   a_result_busy: assert property (@(posedge clock) disable iff (reset)
      core_res_valid |-> !core_in_ready)
      else $error("input open while a result is pending");

endmodule

/* verif/tb_lidar_point_box_classifier.sv */
// Self-checking testbench of the lidar point box classifier: it projects points
// through its own copy of the camera matrices and box set and compares every result.
// It depends on lpbc_pkg and the lidar_point_box_classifier top level.
module tb_lidar_point_box_classifier;
   import lpbc_pkg::*;

   localparam int  LIMIT_CYCLES = 1500000;
   localparam longint MAXI = 64'sh7FFF_FFFF_FFFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_wen = 1'b0;
   logic [2:0] csr_index = '0;
   logic [11:0] csr_wdata = '0;

   lidar_point_box_classifier u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // Predictor state
   longint coef_tbl[NUM_COEFS];
   box_type box_tbl[MAX_BOXES];
   int box_cnt = 0;
   bit set_held = 0;
   longint img_w = 640, img_h = 480, margin = 0;
   longint cam_shift[3] = '{640, 1280, 0};

   req_type item_backlog[$];
   res_type verdict_queue[$];
   int nominal_coef[NUM_COEFS];
   int items_queued = 0;
   int errors = 0;
   int cycles = 0;

   function automatic longint sat_sum(longint a, longint b);
      if (b > 0 && a > MAXI - b) return MAXI;
      if (b < 0 && a < -MAXI - b) return -MAXI;
      return a + b;
   endfunction

   function automatic longint div_q4(longint n, longint d);
      bit neg;
      longint unsigned un, ud, q, rm, mag;
      neg = (n < 0) != (d < 0);
      un = (n < 0) ? -n : n;
      ud = (d < 0) ? -d : d;
      q = un / ud;
      rm = un % ud;
      if (q >= 64'd67108864) begin
         mag = 64'd1073741824;
      end else begin
         mag = q;
         for (int i = 0; i < 4; i++) begin
            rm = rm << 1;
            mag = mag << 1;
            if (rm >= ud) begin
               rm = rm - ud;
               mag = mag | 64'd1;
            end
         end
      end
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic logic signed [15:0] clip16(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic bit project(int cam, input longint p[3], output longint col,
                                  output longint row);
      longint acc[3];
      longint s;
      col = 0;
      row = 0;
      for (int r = 0; r < 3; r++) begin
         s = coef_tbl[cam*12 + r*4 + 3] * 65536;
         for (int k = 0; k < 3; k++) s = sat_sum(s, coef_tbl[cam*12 + r*4 + k] * p[k]);
         acc[r] = s;
      end
      if (acc[2] == 0) return 0;
      col = div_q4(acc[0], acc[2]);
      row = div_q4(acc[1], acc[2]);
      return col >= 0 && col <= img_w * 16 && row >= 0 && row <= img_h * 16;
   endfunction

   function automatic void classify_item(req_type it);
      longint p[3];
      longint col, row, sh, c2, r2;
      int cam;
      bit blue, yellow, hit;
      res_type r;
      col = 0;
      row = 0;
      blue = 0;
      yellow = 0;
      case (it.command)
         CMD_COEF: begin
            if (it.coef_index < NUM_COEFS) coef_tbl[it.coef_index] = longint'($signed(it.coef_value));
         end
         CMD_BOX: begin
            if (!set_held) begin
               if (box_cnt < MAX_BOXES) begin
                  box_tbl[box_cnt] = '{it.box_xmin, it.box_xmax, it.box_ymin, it.box_ymax,
                                       it.box_class};
                  box_cnt++;
               end
               if (it.group_last) set_held = 1;
            end
         end
         CMD_POINT: begin
            p[0] = longint'($signed(it.point_x));
            p[1] = longint'($signed(it.point_y));
            p[2] = longint'($signed(it.point_z));
            cam = 0;
            hit = 0;
            while (cam < 3 && !hit) begin
               hit = project(cam, p, c2, r2);
               if (c2 != 0 || r2 != 0 || hit) begin
                  col = c2;
                  row = r2;
               end
               if (!hit) cam++;
            end
            if (cam == 3) begin
               col = 0;
               row = 0;
            end
            if (!set_held) begin
               r.verdict = VERDICT_NO_SET;
            end else if (cam == 3) begin
               r.verdict = VERDICT_OOV;
            end else begin
               sh = cam_shift[cam];
               for (int i = 0; i < box_cnt; i++) begin
                  if (col >= (longint'(box_tbl[i].xmin) - sh - margin) * 16 &&
                      col <= (longint'(box_tbl[i].xmax) - sh + margin) * 16 &&
                      row >= (longint'(box_tbl[i].ymin) - margin) * 16 &&
                      row <= (longint'(box_tbl[i].ymax) + margin) * 16) begin
                     if (cam == 1) begin
                        if (box_tbl[i].cls == 2'd1) yellow = 1; else blue = 1;
                     end else begin
                        if (box_tbl[i].cls == 2'd0) blue = 1; else yellow = 1;
                     end
                  end
               end
               r.verdict = blue ? (yellow ? VERDICT_BOTH : VERDICT_BLUE)
                                : (yellow ? VERDICT_YELLOW : VERDICT_NONE);
            end
            r.camera_used = cam_type'(cam[1:0]);
            r.pixel_col = clip16(col);
            r.pixel_row = clip16(row);
            r.echo_x = it.point_x;
            r.echo_y = it.point_y;
            r.echo_z = it.point_z;
            verdict_queue.push_back(r);
            if (it.group_last) begin
               set_held = 0;
               box_cnt = 0;
            end
         end
         default: ;
      endcase
   endfunction

   // Item sources
   function automatic req_type rnd_item();
      logic [191:0] raw;
      req_type it;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      it = raw[$bits(req_type)-1:0];
      return it;
   endfunction

   task automatic queue_item(req_type it);
      item_backlog.push_back(it);
      items_queued++;
   endtask

   task automatic queue_null();
      req_type it;
      it = rnd_item();
      it.command = CMD_NONE;
      queue_item(it);
   endtask

   task automatic queue_coef(int idx, logic [31:0] val);
      req_type it;
      it = rnd_item();
      it.command = CMD_COEF;
      it.coef_index = idx[5:0];
      it.coef_value = val;
      queue_item(it);
   endtask

   task automatic queue_box(int x0, int x1, int y0, int y1, int cls, bit last);
      req_type it;
      it = rnd_item();
      it.command = CMD_BOX;
      it.box_xmin = x0[11:0];
      it.box_xmax = x1[11:0];
      it.box_ymin = y0[11:0];
      it.box_ymax = y1[11:0];
      it.box_class = cls[1:0];
      it.group_last = last;
      queue_item(it);
   endtask

   task automatic queue_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit last);
      req_type it;
      it = rnd_item();
      it.command = CMD_POINT;
      it.point_x = x;
      it.point_y = y;
      it.point_z = z;
      it.group_last = last;
      queue_item(it);
   endtask

   // Aims a point at a column of the combined frame and a row, at a random depth.
   task automatic queue_aimed(int c, int row, bit last);
      longint zq, x, y;
      zq = $urandom_range(65536, 60 * 65536);
      x = longint'(c - 960) * zq / 200;
      y = longint'(row - 240) * zq / 200;
      queue_point(x[31:0], y[31:0], zq[31:0], last);
   endtask

   task automatic load_matrices();
      int cx[3];
      cx = '{320, -320, 960};
      for (int c = 0; c < 3; c++) begin
         nominal_coef[c*12 + 0]  = 200 * 65536;
         nominal_coef[c*12 + 1]  = 0;
         nominal_coef[c*12 + 2]  = cx[c] * 65536;
         nominal_coef[c*12 + 3]  = 0;
         nominal_coef[c*12 + 4]  = 0;
         nominal_coef[c*12 + 5]  = 200 * 65536;
         nominal_coef[c*12 + 6]  = 240 * 65536;
         nominal_coef[c*12 + 7]  = 0;
         nominal_coef[c*12 + 8]  = 0;
         nominal_coef[c*12 + 9]  = 0;
         nominal_coef[c*12 + 10] = 65536;
         nominal_coef[c*12 + 11] = 0;
      end
      for (int i = 0; i < NUM_COEFS; i++) queue_coef(i, nominal_coef[i]);
   endtask

   task automatic queue_noise();
      int sel, idx;
      sel = $urandom_range(0, 99);
      idx = $urandom_range(0, 35);
      if (sel < 35) begin
         queue_null();
      end else if (sel < 70) begin
         queue_coef($urandom_range(36, 63), $urandom);
      end else if (sel < 97) begin
         queue_coef(idx, nominal_coef[idx] + $urandom_range(0, 8191) - 4096);
      end else begin
         queue_coef(idx, $urandom);
      end
   endtask

   task automatic queue_group();
      int nb, np, sel, bx[8], by[8], bw[8], bh[8], kept;
      sel = $urandom_range(0, 99);
      nb = (sel < 6) ? 0 : (sel < 10) ? $urandom_range(65, 70) : $urandom_range(1, 8);
      kept = 0;
      for (int i = 0; i < nb; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            queue_box($urandom, $urandom, $urandom, $urandom, $urandom, i == nb - 1);
         end else begin
            if (kept < 8) begin
               bx[kept] = $urandom_range(0, 1900);
               by[kept] = $urandom_range(0, 470);
               bw[kept] = $urandom_range(2, 300);
               bh[kept] = $urandom_range(2, 200);
               queue_box(bx[kept], bx[kept] + bw[kept], by[kept], by[kept] + bh[kept],
                         $urandom_range(0, 3), i == nb - 1);
               kept++;
            end else begin
               queue_box($urandom_range(0, 1900), $urandom_range(0, 4095),
                         $urandom_range(0, 470), $urandom_range(0, 4095),
                         $urandom_range(0, 3), i == nb - 1);
            end
         end
         if ($urandom_range(0, 19) == 0) queue_noise();
      end
      if ($urandom_range(0, 4) == 0)
         queue_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1));
      np = $urandom_range(1, 8);
      for (int i = 0; i < np; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 65 && kept > 0) begin
            sel = $urandom_range(0, kept - 1);
            queue_aimed(bx[sel] + $urandom_range(0, bw[sel] + 8) - 4,
                        by[sel] + $urandom_range(0, bh[sel] + 8) - 4, i == np - 1);
         end else if (sel < 85) begin
            queue_aimed($urandom_range(0, 2800) - 400, $urandom_range(0, 800) - 150, i == np - 1);
         end else if (sel < 92) begin
            queue_point($urandom, $urandom, 32'h0, i == np - 1);
         end else begin
            queue_point($urandom, $urandom, $urandom, i == np - 1);
         end
         if ($urandom_range(0, 14) == 0) queue_noise();
      end
   endtask

   // Sender: bursts of random length with random gaps
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      req_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (item_backlog.size() > 0) begin
            it = item_backlog.pop_front();
            classify_item(it);
            req_tdata <= {it.point_z, it.point_y, it.point_x, it.box_class, it.box_ymax,
                          it.box_ymin, it.box_xmax, it.box_xmin, it.coef_value, it.coef_index};
            req_tuser <= it.command;
            req_tlast <= it.group_last;
            req_tvalid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: stall pattern that changes from time to time
   int stall_mode = 0;
   int stall_left = 0;

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 400);
      end else begin
         stall_left = stall_left - 1;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= $urandom_range(0, 1);
         2: rsp_tready <= ($urandom_range(0, 7) == 0);
         default: rsp_tready <= (cycles % 5 != 0);
      endcase
   end

   task automatic report(string what, longint got, longint want);
      $display("ERROR at cycle %0d: %s is %0d, expected %0d", cycles, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      res_type want;
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdict_queue.size() == 0) begin
            $display("ERROR at cycle %0d: result item with none expected", cycles);
            errors++;
         end else begin
            want = verdict_queue.pop_front();
            if (rsp_tdata[1:0] != want.camera_used)
               report("camera_used", rsp_tdata[1:0], want.camera_used);
            if (rsp_tdata[4:2] != want.verdict)
               report("verdict", rsp_tdata[4:2], want.verdict);
            if (rsp_tdata[20:5] != want.pixel_col)
               report("pixel_col", $signed(rsp_tdata[20:5]), want.pixel_col);
            if (rsp_tdata[36:21] != want.pixel_row)
               report("pixel_row", $signed(rsp_tdata[36:21]), want.pixel_row);
            if (rsp_tdata[68:37] != want.echo_x)
               report("echo_x", $signed(rsp_tdata[68:37]), want.echo_x);
            if (rsp_tdata[100:69] != want.echo_y)
               report("echo_y", $signed(rsp_tdata[100:69]), want.echo_y);
            if (rsp_tdata[132:101] != want.echo_z)
               report("echo_z", $signed(rsp_tdata[132:101]), want.echo_z);
         end
      end
      if (cycles > LIMIT_CYCLES) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] idx, int val);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[11:0];
      case (idx)
         CSR_IMAGE_WIDTH:  img_w = val & 12'hFFF;
         CSR_IMAGE_HEIGHT: img_h = val & 12'hFFF;
         CSR_MATCH_MARGIN: margin = val & 8'hFF;
         CSR_CENTER_SHIFT: cam_shift[0] = val & 12'hFFF;
         CSR_RIGHT_SHIFT:  cam_shift[1] = val & 12'hFFF;
         CSR_LEFT_SHIFT:   cam_shift[2] = val & 12'hFFF;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_registers(int w, int h, int m, int sc, int sr, int sl);
      csr_write(CSR_IMAGE_WIDTH, w);
      csr_write(CSR_IMAGE_HEIGHT, h);
      csr_write(CSR_MATCH_MARGIN, m);
      csr_write(CSR_CENTER_SHIFT, sc);
      csr_write(CSR_RIGHT_SHIFT, sr);
      csr_write(CSR_LEFT_SHIFT, sl);
      csr_wen <= 1'b0;
   endtask

   task automatic wait_idle();
      while (item_backlog.size() > 0 || req_tvalid || verdict_queue.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   initial begin
      int target;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, under the reset register values
      load_matrices();
      queue_aimed(900, 200, 0);
      queue_box(0, 4095, 0, 4095, 0, 0);
      queue_box(0, 4095, 0, 4095, 1, 0);
      queue_box(700, 800, 100, 200, 2, 0);
      queue_box(4095, 0, 4095, 0, 3, 1);
      queue_box(10, 20, 10, 20, 0, 1);
      queue_coef(36, 32'h8000_0000);
      queue_coef(63, 32'h7FFF_FFFF);
      queue_null();
      queue_aimed(750, 150, 0);
      queue_aimed(1500, 300, 0);
      queue_aimed(300, 100, 0);
      queue_point(32'h0001_0000, 32'h0001_0000, 32'h0, 0);
      queue_point(32'h0001_0000, 32'h0002_0000, 32'hFFF0_0000, 0);
      queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 0);
      queue_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 0);
      queue_coef(2, 32'h7FFF_FFFF);
      queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
      queue_coef(2, 32'h8000_0000);
      queue_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
      queue_coef(2, nominal_coef[2]);
      for (int i = 0; i < 67; i++) queue_box(0, 4095, 0, 4095, i % 4, i == 66);
      queue_aimed(1000, 240, 1);

      for (int phase = 0; phase < 6; phase++) begin
         if (phase > 0) begin
            wait_idle();
            case (phase)
               1: set_registers(4095, 4095, 255, 4095, 4095, 4095);
               2: set_registers(1, 1, 0, 0, 0, 0);
               3: set_registers(640, 480, 3, 640, 1280, 0);
               default: set_registers($urandom_range(1, 4095), $urandom_range(1, 4095),
                                      $urandom_range(0, 255), $urandom_range(0, 4095),
                                      $urandom_range(0, 4095), $urandom_range(0, 4095));
            endcase
            load_matrices();
         end
         target = items_queued + 240;
         while (items_queued < target) queue_group();
      end

      wait_idle();
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

/* files.f */
rtl/core/lpbc_pkg.sv
rtl/core/lpbc_divider.sv
rtl/core/lpbc_core.sv
rtl/core/lidar_point_box_classifier.sv
verif/tb_lidar_point_box_classifier.sv
